### rtl/core/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and byte codes for the info frame receiver / destuffer.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] ADDR_BYTE = 8'h03;
  localparam logic [7:0] CTRL_I0   = 8'h00;
  localparam logic [7:0] CTRL_I1   = 8'h40;
  localparam logic [7:0] RR_0      = 8'h05;
  localparam logic [7:0] RR_1      = 8'h85;
  localparam logic [7:0] REJ_0     = 8'h01;
  localparam logic [7:0] REJ_1     = 8'h81;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1000;

  typedef enum logic [2:0] {
    HS_START = 3'd0,
    HS_FLAG  = 3'd1,
    HS_ADDR  = 3'd2,
    HS_CTRL  = 3'd3,
    HS_DATA  = 3'd4
  } hunt_state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  reply_control;
    logic        frame_sequence;
    logic [15:0] payload_length;
  } ifr_result_t;

endpackage

### rtl/core/info_frame_receiver_destuffer_core.sv
// ----------------------------------------------------------------------------
// info_frame_receiver_destuffer_core
// Byte-stuffed information frame receiver: header hunt, destuffing, check.
// ----------------------------------------------------------------------------
// A line byte is registered in the input register; the result that it yields,
//   if any, is then registered in the result register.
// Throughput: one line byte per cycle while results are taken; while a result
//   waits, one more byte enters the input register, then the input stalls.
// Reset (rst, synchronous): hunt for a flag, expected sequence 1, byte limit
//   1000, both registers empty.
// ----------------------------------------------------------------------------
module info_frame_receiver_destuffer_core import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration: max_payload_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Line byte requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result requests
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data_byte, [15:8] reply_control,
                                 // [16] frame_sequence, [32:17] payload_length,
                                 // [39:33] zero
  output logic [1:0]  m_tuser    // [1:0] kind
);

  logic        in_held;
  logic [7:0]  in_byte;
  logic        advance;
  logic        res_valid;
  ifr_result_t res;
  ifr_result_t res_out;

  // Always taken; user sends configuration only while block idle; not enforced.
  assign cfg_ready = 1'b1;

  // Advance the held byte whenever the result register can take a result.
  assign advance = in_held && (!m_tvalid || m_tready);

  ifr_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .advance   (advance),
    .held      (in_held),
    .held_data (in_byte)
  );

  ifr_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .step      (advance),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load a result only for bytes that produce one.
  ifr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res_in    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_out)
  );

  assign m_tdata = {7'd0, res_out.payload_length, res_out.frame_sequence,
                    res_out.reply_control, res_out.data_byte};
  assign m_tuser = res_out.kind;

  // Input side stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a stalled result");

  // Result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Payload results carry no reply and no length.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PAYLOAD) |->
      (m_tdata[15:8] == 8'd0 && m_tdata[32:17] == 16'd0))
    else $error("payload result with reply or length");

  // An accepted frame always answers with a receiver-ready code.
  a_accept_rr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ACCEPT) |->
      (m_tdata[15:8] == RR_0 || m_tdata[15:8] == RR_1))
    else $error("accept without RR reply");

endmodule

### rtl/core/ifr_in_reg.sv
// ----------------------------------------------------------------------------
// ifr_in_reg
// Input register: holds one received line byte until the deframer takes it.
// ----------------------------------------------------------------------------
module ifr_in_reg import ifr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held,
  output logic [7:0] held_data
);

  logic       valid;
  logic [7:0] data;

  assign in_ready  = !valid || advance;
  assign held      = valid;
  assign held_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
    end
  end

endmodule

### rtl/core/ifr_deframer.sv
// ----------------------------------------------------------------------------
// ifr_deframer
// Header hunt, destuffing, running check and hold-back of the check byte.
// ----------------------------------------------------------------------------
module ifr_deframer import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_value,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output ifr_result_t res
);

  hunt_state_t state, state_next;
  logic        escape_pending, escape_pending_next;
  logic        seq, seq_next;
  logic [7:0]  check_acc, check_acc_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic        expected_nr, expected_nr_next;
  logic [15:0] max_payload;

  logic        take;
  logic [7:0]  take_value;
  logic [7:0]  take_part;
  logic [7:0]  rej_code;

  assign rej_code = expected_nr ? REJ_1 : REJ_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      max_payload <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= HS_START;
      escape_pending <= 1'b0;
      seq            <= 1'b0;
      check_acc      <= '0;
      byte_count     <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      expected_nr    <= 1'b1;
    end else if (step) begin
      state          <= state_next;
      escape_pending <= escape_pending_next;
      seq            <= seq_next;
      check_acc      <= check_acc_next;
      byte_count     <= byte_count_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      expected_nr    <= expected_nr_next;
    end
  end

  always_comb begin
    state_next          = state;
    escape_pending_next = escape_pending;
    seq_next            = seq;
    check_acc_next      = check_acc;
    byte_count_next     = byte_count;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    expected_nr_next    = expected_nr;
    take                = 1'b0;
    take_value          = rx_byte;
    take_part           = rx_byte;
    res_valid           = 1'b0;
    res                 = '0;
    res.frame_sequence  = seq;

    case (state)
      HS_START: begin
        if (rx_byte == FLAG_BYTE) state_next = HS_FLAG;
      end
      HS_FLAG: begin
        if (rx_byte != FLAG_BYTE) begin
          state_next = (rx_byte == ADDR_BYTE) ? HS_ADDR : HS_START;
        end
      end
      HS_ADDR: begin
        if (rx_byte == FLAG_BYTE) begin
          state_next = HS_FLAG;
        end else if (rx_byte == CTRL_I0 || rx_byte == CTRL_I1) begin
          seq_next   = (rx_byte == CTRL_I1);
          state_next = HS_CTRL;
        end else begin
          state_next = HS_START;
        end
      end
      HS_CTRL: begin
        if (rx_byte == FLAG_BYTE) begin
          state_next = HS_FLAG;
        end else if (rx_byte != (ADDR_BYTE ^ (seq ? CTRL_I1 : CTRL_I0))) begin
          state_next = HS_START;
        end else begin
          state_next          = HS_DATA;
          escape_pending_next = 1'b0;
          check_acc_next      = '0;
          byte_count_next     = '0;
          held_byte_next      = '0;
          held_valid_next     = 1'b0;
        end
      end
      HS_DATA: begin
        if (rx_byte == FLAG_BYTE) begin
          // Closing flag: judge the frame, check byte included.
          state_next          = HS_START;
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          res_valid           = 1'b1;
          if (byte_count != '0 && check_acc == '0) begin
            res.kind           = KIND_ACCEPT;
            res.reply_control  = expected_nr ? RR_1 : RR_0;
            res.payload_length = byte_count - 16'd1;
            expected_nr_next   = !expected_nr;
          end else begin
            res.kind          = KIND_REJECT;
            res.reply_control = rej_code;
          end
        end else if (byte_count >= max_payload) begin
          // Drop the byte and the frame.
          state_next          = HS_START;
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          res_valid           = 1'b1;
          res.kind            = KIND_OVERFLOW;
          res.reply_control   = rej_code;
        end else if (rx_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (rx_byte == ESC_FLAG) begin
            take       = 1'b1;
            take_value = FLAG_BYTE;
            take_part  = ESC_BYTE ^ ESC_FLAG;
          end else if (rx_byte == ESC_ESC) begin
            take       = 1'b1;
            take_value = ESC_BYTE;
            take_part  = ESC_BYTE ^ ESC_ESC;
          end
        end else begin
          take = 1'b1;
        end

        if (take) begin
          check_acc_next  = check_acc ^ take_part;
          byte_count_next = byte_count + 16'd1;
          held_byte_next  = take_value;
          held_valid_next = 1'b1;
          if (held_valid) begin
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = held_byte;
          end
        end
      end
      default: begin
        state_next = HS_START;
      end
    endcase
  end

endmodule

### rtl/core/ifr_out_reg.sv
// ----------------------------------------------------------------------------
// ifr_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ifr_out_reg import ifr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  ifr_result_t res_in,
  output logic        out_valid,
  input  logic        out_ready,
  output ifr_result_t res_out
);

  logic        valid;
  ifr_result_t data;

  assign out_valid = valid;
  assign res_out   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

endmodule
